// ===== design/layer_pending_work_picker_top_defines.svh =====
// Assertion macros shared by the layer pending work picker RTL.
// Depends on nothing; every macro samples on clock and is disabled in reset.
`ifndef LAYER_PENDING_WORK_PICKER_TOP_DEFINES_SVH
`define LAYER_PENDING_WORK_PICKER_TOP_DEFINES_SVH

// Same-cycle implication.
`define LPWP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LPWP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lpwp_pkg.sv =====
// Package of the layer pending work picker: sizes, codes and struct types.
// Used by every module of the block; depends on nothing.
package lpwp_pkg;

   localparam int LAYER_COUNT = 32;
   localparam int LAYER_W    = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
   localparam int TOK_W      = 24;
   localparam int BAT_W      = 16;
   localparam int CNT_W      = 16;
   localparam int IDX_W      = 5;
   localparam int GS_W       = 6;
   localparam int MODE_W     = 2;
   localparam int SUM_W      = TOK_W + GS_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [TOK_W-1:0] TOK_MAX = {TOK_W{1'b1}};
   localparam logic [BAT_W-1:0] BAT_MAX = {BAT_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_SIZE  = 1'd1;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_SCHED = 1'b1;

   localparam logic [MODE_W-1:0] POLICY_MOST_TOKENS   = 2'd0;
   localparam logic [MODE_W-1:0] POLICY_FIRST_NONZERO = 2'd1;
   localparam logic [MODE_W-1:0] POLICY_HEAVY_BLOCK   = 2'd2;
   localparam logic [MODE_W-1:0] POLICY_MOST_BATCHES  = 2'd3;

   typedef struct packed {
      logic             func;
      logic [IDX_W-1:0] layer_index;
      logic [CNT_W-1:0] token_count;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] chosen_layer;
      logic             found;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic add;
      logic clear;
   } cell_ctl_type;

   typedef struct packed {
      logic start;
      logic step;
      logic last;
   } scan_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ===== design/lpwp_cell.sv =====
// One ring cell: the token and batch counters of one layer slot.
// Depends on lpwp_pkg.
module lpwp_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  lpwp_pkg::cell_ctl_type      ctl,
   input  logic [lpwp_pkg::CNT_W-1:0]  add_count,
   input  logic [lpwp_pkg::TOK_W-1:0]  shift_tok,
   input  logic [lpwp_pkg::BAT_W-1:0]  shift_bat,
   output logic [lpwp_pkg::TOK_W-1:0]  tok,
   output logic [lpwp_pkg::BAT_W-1:0]  bat
);
   import lpwp_pkg::*;

   logic [TOK_W-1:0] tok_ff, tok_in;
   logic [BAT_W-1:0] bat_ff, bat_in;
   logic [TOK_W:0]   tok_sum;

   assign tok_sum = {1'b0, tok_ff} + {{(TOK_W+1-CNT_W){1'b0}}, add_count};

   always_comb begin
      tok_in = tok_ff;
      bat_in = bat_ff;
      if (ctl.clear) begin
         tok_in = '0;
         bat_in = '0;
      end else if (ctl.shift) begin
         tok_in = shift_tok;
         bat_in = shift_bat;
      end else if (ctl.add) begin
         tok_in = tok_sum[TOK_W] ? TOK_MAX : tok_sum[TOK_W-1:0];
         bat_in = (bat_ff == BAT_MAX) ? bat_ff : bat_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
         bat_ff <= '0;
      end else begin
         tok_ff <= tok_in;
         bat_ff <= bat_in;
      end
   end

   assign tok = tok_ff;
   assign bat = bat_ff;

endmodule

// ===== design/lpwp_scan.sv =====
// Scan unit: watches the layers as they pass the ring head and keeps the best pick.
// Depends on lpwp_pkg.
module lpwp_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  lpwp_pkg::scan_ctl_type       ctl,
   input  logic [lpwp_pkg::MODE_W-1:0]  policy,
   input  logic [lpwp_pkg::GS_W-1:0]    group_size,
   input  logic [lpwp_pkg::LAYER_W-1:0] pos,
   input  logic [lpwp_pkg::TOK_W-1:0]   head_tok,
   input  logic [lpwp_pkg::BAT_W-1:0]   head_bat,
   output logic [lpwp_pkg::LAYER_W-1:0] best_idx,
   output logic                         best_found
);
   import lpwp_pkg::*;

   logic               have_ff, have_in;
   logic [LAYER_W-1:0] best_ff, best_in;
   logic [TOK_W-1:0]   best_t_ff, best_t_in;
   logic [BAT_W-1:0]   best_b_ff, best_b_in;
   logic [SUM_W-1:0]   best_sum_ff, best_sum_in;
   logic [SUM_W-1:0]   blk_sum_ff, blk_sum_in;
   logic [GS_W-1:0]    blk_pos_ff, blk_pos_in;
   logic [LAYER_W-1:0] blk_first_ff, blk_first_in;
   logic               blk_first_v_ff, blk_first_v_in;
   logic [GS_W-1:0]    gs_eff;
   logic               blk_end;
   logic               nonzero;

   assign gs_eff  = (group_size == '0) ? GS_W'(1) : group_size;
   assign blk_end = (blk_pos_ff == gs_eff - 1'b1) || ctl.last;
   assign nonzero = (head_tok != '0);

   always_comb begin
      have_in        = have_ff;
      best_in        = best_ff;
      best_t_in      = best_t_ff;
      best_b_in      = best_b_ff;
      best_sum_in    = best_sum_ff;
      blk_sum_in     = blk_sum_ff;
      blk_pos_in     = blk_pos_ff;
      blk_first_in   = blk_first_ff;
      blk_first_v_in = blk_first_v_ff;
      if (ctl.start) begin
         have_in        = 1'b0;
         best_in        = '0;
         best_t_in      = '0;
         best_b_in      = '0;
         best_sum_in    = '0;
         blk_sum_in     = '0;
         blk_pos_in     = '0;
         blk_first_v_in = 1'b0;
      end else if (ctl.step) begin
         case (policy)
            POLICY_MOST_TOKENS: begin
               if ((pos == '0) || (head_tok > best_t_ff)) begin
                  have_in   = 1'b1;
                  best_in   = pos;
                  best_t_in = head_tok;
               end
            end
            POLICY_FIRST_NONZERO: begin
               if (!have_ff && nonzero) begin
                  have_in = 1'b1;
                  best_in = pos;
               end
            end
            POLICY_HEAVY_BLOCK: begin
               // Running sum of the current block and its first nonempty layer.
               blk_sum_in = ((blk_pos_ff == '0) ? '0 : blk_sum_ff)
                            + {{(SUM_W-TOK_W){1'b0}}, head_tok};
               if ((blk_pos_ff == '0) || !blk_first_v_ff) begin
                  blk_first_v_in = nonzero;
                  blk_first_in   = pos;
               end
               if (blk_end) begin
                  blk_pos_in = '0;
                  if (blk_sum_in > best_sum_ff) begin
                     have_in     = 1'b1;
                     best_in     = blk_first_in;
                     best_sum_in = blk_sum_in;
                  end
               end else begin
                  blk_pos_in = blk_pos_ff + 1'b1;
               end
            end
            default: begin
               if ((head_bat > best_b_ff) ||
                   ((head_bat == best_b_ff) && (head_tok > best_t_ff))) begin
                  have_in   = 1'b1;
                  best_in   = pos;
                  best_b_in = head_bat;
                  best_t_in = head_tok;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff        <= best_in;
      best_t_ff      <= best_t_in;
      best_b_ff      <= best_b_in;
      best_sum_ff    <= best_sum_in;
      blk_sum_ff     <= blk_sum_in;
      blk_pos_ff     <= blk_pos_in;
      blk_first_ff   <= blk_first_in;
      blk_first_v_ff <= blk_first_v_in;
   end

   assign best_idx   = best_ff;
   assign best_found = have_ff;

endmodule

// ===== design/layer_pending_work_picker_top.sv =====
// Top level of the layer pending work picker: ring of layer cells, scan unit,
// sequencer and result register. Depends on lpwp_pkg, lpwp_cell and lpwp_scan.
//
// Usage:
// Items arrive on the req_ channel (valid/stall); a transfer happens at a clock
// edge with req_valid high and req_stall low. An add item (func 0) adds its
// token count to one layer and bumps that layer's batch count; it gives no
// result. A schedule item (func 1) picks a layer by the policy in the
// policy_mode register and returns one result on the rsp_ channel.
// A schedule rotates all LAYER_COUNT counters once past the scan unit, one layer
// per cycle, and occupies the block until its finish step has posted the
// result; the next item is taken once the block is back in idle. The rotation
// through the ring of cells sets how long a schedule takes. The result sits in
// an output register, so adds keep flowing while it waits; a second schedule
// holds at its final step until that register is free. Synchronous reset
// clears all counters, sets policy_mode to 1 and group_size to 1, and empties
// the result register. Configuration is written through the csr_ port while the
// block is idle.
module layer_pending_work_picker_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  lpwp_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output lpwp_pkg::rsp_type              rsp_data,
   input  logic                           csr_write_enable,
   input  logic [lpwp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lpwp_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import lpwp_pkg::*;

`include "layer_pending_work_picker_top_defines.svh"

   // Configuration registers.
   logic [MODE_W-1:0] policy_ff;
   logic [GS_W-1:0]   group_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= POLICY_FIRST_NONZERO;
         group_size_ff <= GS_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_POLICY_MODE: policy_ff     <= csr_write_data[MODE_W-1:0];
            CSR_GROUP_SIZE:  group_size_ff <= csr_write_data[GS_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer state, scan position and result register.
   state_type          state_ff, state_in;
   logic [LAYER_W-1:0] pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_xfer;
   logic               slot_free;
   logic               do_add;
   logic               do_clear;
   logic               do_shift;
   scan_ctl_type       scan_ctl;
   logic [LAYER_W-1:0] best_idx;
   logic               best_found;

   assign req_xfer  = req_valid && !req_stall;
   // The result register can take a new result when empty or when its content
   // transfers in this cycle.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      req_stall      = 1'b1;
      do_add         = 1'b0;
      do_clear       = 1'b0;
      do_shift       = 1'b0;
      scan_ctl.start = 1'b0;
      scan_ctl.step  = 1'b0;
      scan_ctl.last  = (pos_ff == LAYER_W'(LAYER_COUNT - 1));
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_xfer) begin
               if (req_data.func == FUNC_SCHED) begin
                  scan_ctl.start = 1'b1;
                  pos_in         = '0;
                  state_in       = ST_SCAN;
               end else begin
                  do_add = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // The layer at position pos sits in cell 0 this cycle.
            do_shift      = 1'b1;
            scan_ctl.step = 1'b1;
            pos_in        = pos_ff + 1'b1;
            if (scan_ctl.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The ring is back in home position; clear the pick and report it.
            if (slot_free) begin
               do_clear                 = best_found;
               rsp_valid_in             = 1'b1;
               rsp_data_in.found        = best_found;
               rsp_data_in.chosen_layer = best_found ? IDX_W'(best_idx) : '0;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Ring of cells. During a scan each cell takes its upper neighbor's
   // counters, so layers pass cell 0 in ascending order and return home after
   // LAYER_COUNT shifts.
   logic [TOK_W-1:0] cell_tok [LAYER_COUNT];
   logic [BAT_W-1:0] cell_bat [LAYER_COUNT];

   for (genvar k = 0; k < LAYER_COUNT; k++) begin : g_cell
      localparam int NEXT = (k + 1) % LAYER_COUNT;
      cell_ctl_type ctl;

      assign ctl.shift = do_shift;
      // An add to a layer beyond the ring matches no cell and is dropped.
      assign ctl.add   = do_add &&
                         ({{(32-IDX_W){1'b0}}, req_data.layer_index} == 32'(k));
      assign ctl.clear = do_clear && (best_idx == LAYER_W'(k));

      lpwp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .add_count (req_data.token_count),
         .shift_tok (cell_tok[NEXT]),
         .shift_bat (cell_bat[NEXT]),
         .tok       (cell_tok[k]),
         .bat       (cell_bat[k])
      );
   end

   lpwp_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .policy     (policy_ff),
      .group_size (group_size_ff),
      .pos        (pos_ff),
      .head_tok   (cell_tok[0]),
      .head_bat   (cell_bat[0]),
      .best_idx   (best_idx),
      .best_found (best_found)
   );

   // The scan walks every position once, one per cycle.
   `LPWP_ASSERT_NEXT(a_pos_advance, (state_ff == ST_SCAN) && !scan_ctl.last,
      (state_ff == ST_SCAN) && (pos_ff == $past(pos_ff) + 1'b1),
      "scan position did not advance")
   // A scan ends in the finish step right after the last position.
   `LPWP_ASSERT_NEXT(a_scan_end, (state_ff == ST_SCAN) && scan_ctl.last,
      state_ff == ST_FINISH, "scan did not end after the last layer")
   // A finish with room for the result always produces one.
   `LPWP_ASSERT_NEXT(a_finish_rsp, (state_ff == ST_FINISH) && slot_free,
      rsp_valid_ff && (state_ff == ST_IDLE), "finish step did not post a result")
   // A result without a pick reports layer zero.
   `LPWP_ASSERT_NOW(a_none_zero, rsp_valid_ff && !rsp_data_ff.found,
      rsp_data_ff.chosen_layer == '0, "empty pick with nonzero layer")

endmodule

// ===== tb/layer_pending_work_picker_top_tb.sv =====
// Self-checking testbench of layer_pending_work_picker_top: directed picks, counter saturation
// and randomized add/schedule traffic under all four policies, with random back-pressure.
// Depends on lpwp_pkg and the block's RTL only.
module layer_pending_work_picker_top_tb;
   import lpwp_pkg::*;

   // Cycles the block may still spend on work after the last result (a full scan plus margin).
   localparam int SETTLE_CYCLES = LAYER_COUNT + 8;
   localparam int RANDOM_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 66;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   layer_pending_work_picker_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the block's counters and registers. It is advanced at the clock edge
   // of each accepted transfer and register write, so it always matches what the block
   // has seen.
   logic [TOK_W-1:0]  tokens_held [LAYER_COUNT];
   logic [BAT_W-1:0]  batches_held [LAYER_COUNT];
   logic [MODE_W-1:0] policy_sel;
   logic [GS_W-1:0]   block_len;

   req_type items_to_send [$];
   rsp_type picks_due [$];
   rsp_type oldest_pick;

   int          send_idle_pct;
   int          rsp_idle_pct;
   int unsigned hold_cycles;
   bit          req_took;
   int          error_count;
   int          requests_in;
   int          picks_checked;
   int          picks_empty;
   int          settings_used;

   // Lowest layer in [lo, hi) that holds tokens, or -1 when there is none.
   function automatic int first_loaded(int lo, int hi);
      int i;
      for (i = lo; i < hi; i++) begin
         if (tokens_held[i] != '0) return i;
      end
      return -1;
   endfunction

   // Add transfer: both counters of the layer grow and stop at their maximum.
   function automatic void bump_layer(logic [IDX_W-1:0] layer, logic [CNT_W-1:0] count);
      logic [TOK_W:0] total;
      if (int'(layer) < LAYER_COUNT) begin
         total = {1'b0, tokens_held[layer]} + count;
         tokens_held[layer] = total[TOK_W] ? TOK_MAX : total[TOK_W-1:0];
         if (batches_held[layer] != BAT_MAX) batches_held[layer] = batches_held[layer] + 1'b1;
      end
   endfunction

   // Schedule transfer: choose a layer by the active policy, clear it and return the pick.
   function automatic rsp_type pick_layer();
      int             win;
      int             i;
      int             j;
      int             span;
      int             blk_end;
      logic [SUM_W-1:0] acc;
      logic [SUM_W-1:0] heaviest;
      logic [BAT_W-1:0] top_batches;
      logic [TOK_W-1:0] top_tokens;
      rsp_type        pick;
      win = -1;
      case (policy_sel)
         POLICY_MOST_TOKENS: begin
            // Always finds a layer; with every counter empty that is layer 0.
            win = 0;
            for (i = 1; i < LAYER_COUNT; i++) begin
               if (tokens_held[i] > tokens_held[win]) win = i;
            end
         end
         POLICY_FIRST_NONZERO: begin
            win = first_loaded(0, LAYER_COUNT);
         end
         POLICY_HEAVY_BLOCK: begin
            span = (block_len == '0) ? 1 : int'(block_len);
            heaviest = '0;
            for (i = 0; i < LAYER_COUNT; i += span) begin
               acc = '0;
               blk_end = (i + span < LAYER_COUNT) ? i + span : LAYER_COUNT;
               for (j = i; j < blk_end; j++) acc = acc + tokens_held[j];
               if (acc > heaviest) begin
                  heaviest = acc;
                  win = i;
               end
            end
            if (win >= 0) begin
               win = first_loaded(win, (win + span < LAYER_COUNT) ? win + span : LAYER_COUNT);
            end
         end
         default: begin
            // Most batches, ties going to more tokens; an all-empty layer never wins.
            top_batches = '0;
            top_tokens = '0;
            for (i = 0; i < LAYER_COUNT; i++) begin
               if (batches_held[i] > top_batches ||
                   (batches_held[i] == top_batches && tokens_held[i] > top_tokens)) begin
                  win = i;
                  top_batches = batches_held[i];
                  top_tokens = tokens_held[i];
               end
            end
         end
      endcase
      pick.found = (win >= 0);
      pick.chosen_layer = '0;
      if (win >= 0) begin
         pick.chosen_layer = win[IDX_W-1:0];
         tokens_held[win] = '0;
         batches_held[win] = '0;
      end
      return pick;
   endfunction

   function automatic req_type make_req(logic func, logic [IDX_W-1:0] layer,
                                        logic [CNT_W-1:0] count);
      req_type item;
      item.func = func;
      item.layer_index = layer;
      item.token_count = count;
      return item;
   endfunction

   // Random item. Layers are often drawn from a few hot spots so that ties, heavy blocks
   // and batch races come up; token counts mix zero, the maximum, small and full-range values.
   function automatic req_type random_req();
      logic [IDX_W-1:0] layer;
      logic [CNT_W-1:0] count;
      case ($urandom_range(9))
         0, 1, 2, 3: layer = IDX_W'($urandom_range(LAYER_COUNT - 1));
         4, 5, 6:    layer = IDX_W'($urandom_range(3));
         default:    layer = IDX_W'($urandom_range(LAYER_COUNT - 1, LAYER_COUNT - 4));
      endcase
      case ($urandom_range(9))
         0:          count = '0;
         1:          count = '1;
         2, 3, 4:    count = CNT_W'($urandom_range(255, 1));
         default:    count = CNT_W'($urandom);
      endcase
      // Schedule items carry random junk in the fields they ignore.
      return make_req(($urandom_range(99) < 30) ? FUNC_SCHED : FUNC_ADD, layer, count);
   endfunction

   always #4 clock = ~clock;

   // Register writes land at the clock edge with the enable high. Both registers are
   // written back to back and the enable drops once, so it never sees two updates in
   // one time step.
   task automatic set_policy(logic [MODE_W-1:0] mode, logic [GS_W-1:0] gsize);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_POLICY_MODE;
      csr_write_data <= CSR_DATA_W'(mode);
      @(negedge clock);
      csr_index <= CSR_GROUP_SIZE;
      csr_write_data <= CSR_DATA_W'(gsize);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // Waits until every queued item has gone in and every pick has come back, then lets
   // a full scan's worth of cycles pass, since a trailing add gives no result to wait on.
   task automatic wait_idle();
      while (items_to_send.size() != 0 || req_valid || picks_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_add(logic [IDX_W-1:0] layer, logic [CNT_W-1:0] count);
      items_to_send = {items_to_send, make_req(FUNC_ADD, layer, count)};
   endtask

   task automatic queue_pick();
      items_to_send = {items_to_send, make_req(FUNC_SCHED, '0, '0)};
   endtask

   // Shadow model update on every rising edge, from the values sampled there.
   always @(posedge clock) begin
      req_took = !reset && req_valid && !req_stall;
      if (reset) begin
         for (int i = 0; i < LAYER_COUNT; i++) begin
            tokens_held[i] = '0;
            batches_held[i] = '0;
         end
         policy_sel = POLICY_FIRST_NONZERO;
         block_len = GS_W'(1);
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_POLICY_MODE) policy_sel = csr_write_data[MODE_W-1:0];
            else if (csr_index == CSR_GROUP_SIZE) block_len = csr_write_data[GS_W-1:0];
         end
         if (req_took) begin
            requests_in++;
            if (req_data.func == FUNC_ADD) bump_layer(req_data.layer_index, req_data.token_count);
            else picks_due = {picks_due, pick_layer()};
         end
      end
   end

   // Request driver: a new item goes out only after the previous transfer completed, so a
   // stalled payload stays put. Gaps are inserted at random at the falling edge.
   always @(negedge clock) begin
      if (!req_valid || req_took) begin
         if (!reset && items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= items_to_send[0];
            items_to_send.delete(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure: random stalls plus an optional long hold-off.
   always @(negedge clock) begin
      rsp_stall <= (hold_cycles != 0) || ($urandom_range(99) < rsp_idle_pct);
   end

   // The long hold-off counts down here, one per clock, once the stimulus arms it.
   always @(posedge clock) begin
      if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
   end

   // Result checker: every pick transfer must match the oldest outstanding prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (picks_due.size() == 0) begin
            $error("pick result with none outstanding: chosen_layer %0d found %0b",
                   rsp_data.chosen_layer, rsp_data.found);
            error_count++;
         end else begin
            oldest_pick = picks_due[0];
            picks_due.delete(0);
            picks_checked++;
            if (!oldest_pick.found) picks_empty++;
            if (rsp_data.chosen_layer !== oldest_pick.chosen_layer) begin
               $error("chosen_layer expected %0d actual %0d",
                      oldest_pick.chosen_layer, rsp_data.chosen_layer);
               error_count++;
            end
            if (rsp_data.found !== oldest_pick.found) begin
               $error("found expected %0b actual %0b", oldest_pick.found, rsp_data.found);
               error_count++;
            end
         end
      end
   end

   // Stimulus sequence.
   initial begin
      logic [MODE_W-1:0] phase_mode [RANDOM_PHASES];
      logic [GS_W-1:0]   phase_gsize [RANDOM_PHASES];
      int                p;
      int                n;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      hold_cycles = 0;
      send_idle_pct = 38;
      rsp_idle_pct = 75;
      error_count = 0;
      requests_in = 0;
      picks_checked = 0;
      picks_empty = 0;
      settings_used = 1;
      phase_mode = '{POLICY_MOST_TOKENS, POLICY_FIRST_NONZERO, POLICY_HEAVY_BLOCK,
                     POLICY_MOST_BATCHES, POLICY_HEAVY_BLOCK, POLICY_MOST_TOKENS,
                     POLICY_HEAVY_BLOCK, POLICY_MOST_BATCHES, POLICY_HEAVY_BLOCK,
                     POLICY_FIRST_NONZERO, POLICY_HEAVY_BLOCK, POLICY_MOST_BATCHES};
      phase_gsize = '{1, 32, 1, 5, 32, 63, 0, 1, 3, 8, 7, 16};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // First nonempty with the reset settings: an empty pick finds nothing, a zero-token
      // add leaves the layer ineligible, and the field extremes are exercised.
      queue_pick();
      queue_add(0, 0);
      queue_add(IDX_W'(LAYER_COUNT - 1), '1);
      queue_add(16, 1);
      queue_pick();
      queue_pick();
      queue_pick();
      wait_idle();

      // Most tokens: with all tokens empty layer 0 still wins and loses its stray batch;
      // a tie goes to the lower layer.
      set_policy(POLICY_MOST_TOKENS, 1);
      queue_pick();
      queue_pick();
      queue_add(5, 16'h8000);
      queue_add(6, 16'h8000);
      queue_pick();
      queue_pick();
      wait_idle();

      // Heaviest block with a zero block size (acts as one), then one block covering all.
      set_policy(POLICY_HEAVY_BLOCK, 0);
      queue_add(3, 10);
      queue_add(4, 5);
      queue_add(IDX_W'(LAYER_COUNT - 1), 1);
      queue_pick();
      wait_idle();
      set_policy(POLICY_HEAVY_BLOCK, 32);
      queue_pick();
      queue_pick();
      queue_pick();
      wait_idle();

      // Most batches: the batch count outranks tokens, a zero-token layer with batches can
      // win, and with nothing left no layer is found.
      set_policy(POLICY_MOST_BATCHES, 63);
      queue_add(2, 0);
      queue_add(7, 9);
      queue_add(7, 0);
      queue_pick();
      queue_pick();
      queue_pick();
      wait_idle();

      // Randomized traffic. The first third runs with the sender idle less often than a
      // sluggish receiver, the second third the other way round, the rest flat out.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         if (p < RANDOM_PHASES / 3) begin
            send_idle_pct = 38;
            rsp_idle_pct = 75;
         end else if (p < 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 75;
            rsp_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (p == 10) phase_gsize[p] = GS_W'($urandom_range(63, 1));
         set_policy(phase_mode[p], phase_gsize[p]);
         // One flat-out phase starts with the receiver held off for a long stretch while
         // the sender keeps offering, so a waiting pick blocks the next schedule and the
         // block stalls its input.
         if (p == RANDOM_PHASES - 3) hold_cycles = 600;
         for (n = 0; n < ITEMS_PER_PHASE; n++) items_to_send = {items_to_send, random_req()};
         queue_pick();
         wait_idle();
      end

      // Counter saturation, flat out. Token counters: a layer driven far past the top must
      // still outweigh a layer that its wrapped value would lose to.
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      set_policy(POLICY_MOST_TOKENS, 1);
      for (n = 0; n < 260; n++) queue_add(11, '1);
      for (n = 0; n < 5; n++) queue_add(12, '1);
      queue_pick();
      queue_pick();
      wait_idle();

      if (picks_due.size() != 0) begin
         $error("%0d predicted picks never arrived", picks_due.size());
         error_count++;
      end
      $display("Covered %0d request transfers and %0d checked picks (%0d with no layer found)",
               requests_in, picks_checked, picks_empty);
      $display("over %0d register settings, all four policies, saturation and a long hold-off.",
               settings_used);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, including the saturation burst.
   initial begin
      #8000000;
      $error("simulation watchdog expired");
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/lpwp_pkg.sv
design/lpwp_cell.sv
design/lpwp_scan.sv
design/layer_pending_work_picker_top.sv
tb/layer_pending_work_picker_top_tb.sv
